// ----- design/ssm_pkg.sv -----
// ssm_pkg: shared constants, types and helpers for the substring search matcher
// used by ssm_cell and substring_search_matcher; depends on nothing else
package ssm_pkg;

   // needle and buffer sizing
   localparam int MAX_NEEDLE   = 16;
   localparam int BUFFER_LIMIT = 65536;
   localparam int SEEN_WIDTH   = $clog2(BUFFER_LIMIT + 1);
   localparam int IDX_WIDTH    = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

   // fixed field widths
   localparam int BYTE_WIDTH   = 8;
   localparam int LEN_WIDTH    = 5;
   localparam int OFFSET_WIDTH = 16;
   localparam int REG_WIDTH    = 64;
   localparam int CSR_IDX_WIDTH = 2;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NEEDLE_LOW  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NEEDLE_HIGH = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NEEDLE_LEN  = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IGNORE_CASE = 2'd3;

   // letter bounds for case folding
   localparam logic [BYTE_WIDTH-1:0] LOWER_A    = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] LOWER_Z    = 8'h7a;
   localparam logic [BYTE_WIDTH-1:0] CASE_DELTA = 8'h20;

   // control shared by every cell of the row
   typedef struct packed {
      logic shift;
      logic fold;
   } cell_ctrl_type;

   // per-cell needle byte and whether the cell takes part in the compare
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] needle_byte;
      logic                  in_use;
   } cell_needle_type;

   // map a-z to A-Z when folding is on
   function automatic logic [BYTE_WIDTH-1:0] fold_byte(input logic [BYTE_WIDTH-1:0] b,
                                                       input logic fold);
      if (fold && b >= LOWER_A && b <= LOWER_Z) begin
         return b - CASE_DELTA;
      end
      return b;
   endfunction

endpackage

// ----- design/ssm_cell.sv -----
// ssm_cell: one window byte of the matcher row with its byte compare
// depends on ssm_pkg
module ssm_cell (
   input  logic                          clock,
   input  ssm_pkg::cell_ctrl_type        ctrl,
   input  ssm_pkg::cell_needle_type      needle,
   input  logic [ssm_pkg::BYTE_WIDTH-1:0] in_byte,
   output logic [ssm_pkg::BYTE_WIDTH-1:0] out_byte,
   output logic                          hit
);

   logic [ssm_pkg::BYTE_WIDTH-1:0] byte_ff;

   // the byte this cell will hold after the shift is what gets compared
   assign hit = !needle.in_use ||
                (ssm_pkg::fold_byte(in_byte, ctrl.fold) ==
                 ssm_pkg::fold_byte(needle.needle_byte, ctrl.fold));

   // shift in from the newer neighbor
   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         byte_ff <= in_byte;
      end
   end

   assign out_byte = byte_ff;

endmodule

// ----- design/substring_search_matcher.sv -----
// substring_search_matcher: streaming first-match finder over a row of byte cells
// depends on ssm_pkg and ssm_cell
//
//   channel | direction | fields                        | handshake
//   req     | in        | data_byte, last_byte          | req_valid / req_ready
//   rsp     | out       | found, match_offset           | rsp_valid / rsp_ready
//   csr     | in        | index, wdata                  | csr_valid / csr_ready
//
// one byte per cycle while req is not stalled: every cell compares its incoming byte in the accept cycle,
// the and of the cell hits is registered straight into the result register.
// result appears the cycle after the byte that causes it; one byte per clock sustained while req is not stalled.
// reset is synchronous and restores the configuration, search state and rsp_valid registers and rearms the search.
// req stalls only while a result waits in the output register and rsp_ready is low.
module substring_search_matcher (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ssm_pkg::BYTE_WIDTH-1:0]   req_data_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [ssm_pkg::OFFSET_WIDTH-1:0] rsp_match_offset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssm_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [ssm_pkg::REG_WIDTH-1:0]    csr_wdata
);

   localparam int N = ssm_pkg::MAX_NEEDLE;
   localparam int B = ssm_pkg::BYTE_WIDTH;

   // configuration registers
   logic [ssm_pkg::REG_WIDTH-1:0] needle_low_ff, needle_high_ff;
   logic [ssm_pkg::LEN_WIDTH-1:0] needle_len_ff;
   logic                          ignore_case_ff;

   // search state
   logic [ssm_pkg::SEEN_WIDTH-1:0] seen_ff, seen_in;
   logic                           found_ff, found_in;

   // result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [ssm_pkg::OFFSET_WIDTH-1:0] rsp_offset_ff, rsp_offset_in;

   logic [2*ssm_pkg::REG_WIDTH-1:0] needle_flat;
   logic [ssm_pkg::LEN_WIDTH-1:0]   act_len, len_m1;
   logic [ssm_pkg::SEEN_WIDTH-1:0]  seen_next;
   logic                            accept, counted, all_hit, hit;
   ssm_pkg::cell_ctrl_type          ctrl;
   ssm_pkg::cell_needle_type        cell_needle [N];
   logic [B-1:0]                    chain [N+1];
   logic [N-1:0]                    cell_hit;

   // configuration writes, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
         needle_len_ff  <= ssm_pkg::LEN_WIDTH'(1);
         ignore_case_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            ssm_pkg::CSR_NEEDLE_LOW:  needle_low_ff  <= csr_wdata;
            ssm_pkg::CSR_NEEDLE_HIGH: needle_high_ff <= csr_wdata;
            ssm_pkg::CSR_NEEDLE_LEN:  needle_len_ff  <= csr_wdata[ssm_pkg::LEN_WIDTH-1:0];
            ssm_pkg::CSR_IGNORE_CASE: ignore_case_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamp the needle length to 1..MAX_NEEDLE
   always_comb begin
      if (needle_len_ff == '0) begin
         act_len = ssm_pkg::LEN_WIDTH'(1);
      end else if (needle_len_ff > ssm_pkg::LEN_WIDTH'(N)) begin
         act_len = ssm_pkg::LEN_WIDTH'(N);
      end else begin
         act_len = needle_len_ff;
      end
   end

   assign len_m1      = act_len - ssm_pkg::LEN_WIDTH'(1);
   assign needle_flat = {needle_high_ff, needle_low_ff};

   // handshake and counting
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign counted   = seen_ff < ssm_pkg::SEEN_WIDTH'(ssm_pkg::BUFFER_LIMIT);
   assign seen_next = seen_ff + ssm_pkg::SEEN_WIDTH'(1);

   assign ctrl.shift = accept && counted;
   assign ctrl.fold  = ignore_case_ff;

   // row of cells: cell k holds window entry k and checks needle byte n-1-k
   assign chain[0] = req_data_byte;

   for (genvar k = 0; k < N; k++) begin : g_cell
      logic [ssm_pkg::LEN_WIDTH-1:0] nidx;
      assign nidx = len_m1 - ssm_pkg::LEN_WIDTH'(k);
      assign cell_needle[k].in_use      = act_len > ssm_pkg::LEN_WIDTH'(k);
      assign cell_needle[k].needle_byte =
         needle_flat[nidx[ssm_pkg::IDX_WIDTH-1:0]*B +: B];

      ssm_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .needle   (cell_needle[k]),
         .in_byte  (chain[k]),
         .out_byte (chain[k+1]),
         .hit      (cell_hit[k])
      );
   end

   // first match of this buffer
   assign all_hit = &cell_hit;
   assign hit     = counted && !found_ff && all_hit &&
                    (seen_next >= ssm_pkg::SEEN_WIDTH'(act_len));

   // next state for search and result register
   always_comb begin
      seen_in       = seen_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (accept) begin
         if (counted) begin
            seen_in = seen_next;
         end
         if (hit) begin
            found_in      = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_found_in  = 1'b1;
            rsp_offset_in = ssm_pkg::OFFSET_WIDTH'(seen_next -
                                                   ssm_pkg::SEEN_WIDTH'(act_len));
         end else if (req_last_byte && !found_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_found_in  = 1'b0;
            rsp_offset_in = '0;
         end
         if (req_last_byte) begin
            seen_in  = '0;
            found_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

   // byte counter never passes the buffer limit
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= ssm_pkg::SEEN_WIDTH'(ssm_pkg::BUFFER_LIMIT))
      else $error("byte counter beyond buffer limit");

   // a final byte rearms the search
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_byte |=> seen_ff == '0 && !found_ff)
      else $error("search not rearmed after final byte");

   // a match mid-buffer sets found and presents a found result
   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && hit && !req_last_byte |=> found_ff && rsp_valid && rsp_found)
      else $error("match not recorded");

   // no second found result inside one buffer
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> !hit)
      else $error("second match reported in one buffer");

endmodule
